[hdl/tlvnp_pkg.sv]
package tlvnp_pkg;

    // Descriptors of the fields that update the kept record.
    localparam logic [7:0] DescGpsTime = 8'hD3;
    localparam logic [7:0] DescAntenna = 8'h49;
    localparam logic [7:0] DescFilter  = 8'h10;
    localparam logic [7:0] DescAiding  = 8'h46;

    // Smallest length byte that covers all data a descriptor needs.
    localparam logic [7:0] MinGpsTime = 8'd10;
    localparam logic [7:0] MinAntenna = 8'd19;
    localparam logic [7:0] MinFilter  = 8'd8;
    localparam logic [7:0] MinAiding  = 8'd9;

    // Number of data bytes kept from one field.
    localparam int CapDepth = 17;
    localparam int CapIdxW  = $clog2(CapDepth);

    // Width of the packed result beat.
    localparam int RecordW = 272;

    typedef logic [CapDepth-1:0][7:0] t_cap_bytes;

    // Commit strobes for one beat, with the data bytes of the field as they
    // stand after this beat has been written.
    typedef struct packed {
        logic       gps_time;
        logic       antenna;
        logic       filter;
        logic       aiding;
        t_cap_bytes bytes;
    } t_commit;

endpackage

[hdl/tlvnp_field_walker.sv]
module tlvnp_field_walker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output tlvnp_pkg::t_commit  o_commit
);

    logic [7:0] r_pos, n_pos;
    logic [7:0] r_size, n_size;
    logic [7:0] r_code, n_code;
    logic       r_halted, n_halted;
    logic [7:0] r_cap [tlvnp_pkg::CapDepth];

    logic [7:0]                 size_now;
    logic [7:0]                 code_now;
    logic [7:0]                 pos_inc;
    logic [7:0]                 data_ofs;
    logic                       field_done;
    logic                       wr_en;
    logic [tlvnp_pkg::CapIdxW-1:0] wr_idx;

    assign data_ofs = r_pos - 8'd2;
    assign wr_idx   = data_ofs[tlvnp_pkg::CapIdxW-1:0];
    assign size_now = (r_pos == 8'd0) ? i_byte : r_size;
    assign code_now = (r_pos == 8'd1) ? i_byte : r_code;
    assign pos_inc  = r_pos + 8'd1;

    always_comb begin
        n_pos      = r_pos;
        n_size     = r_size;
        n_code     = r_code;
        n_halted   = r_halted;
        wr_en      = 1'b0;
        field_done = 1'b0;
        if (i_take && !r_halted) begin
            if (r_pos == 8'd0) begin
                if (i_byte == 8'd0) begin
                    n_halted = 1'b1;
                end else begin
                    n_size = i_byte;
                end
            end else if (r_pos == 8'd1) begin
                n_code = i_byte;
            end else if (data_ofs < 8'(tlvnp_pkg::CapDepth)) begin
                wr_en = 1'b1;
            end
            if (!(r_pos == 8'd0 && i_byte == 8'd0)) begin
                if (pos_inc == size_now) begin
                    n_pos      = 8'd0;
                    field_done = (size_now >= 8'd2);
                end else begin
                    n_pos = pos_inc;
                end
            end
        end
        // The end of the payload drops any partial field and a halt.
        if (i_take && i_last) begin
            n_pos    = 8'd0;
            n_size   = 8'd0;
            n_code   = 8'd0;
            n_halted = 1'b0;
        end
    end

    always_comb begin
        // Bytes as seen by a commit: the beat being written counts already.
        for (int k = 0; k < tlvnp_pkg::CapDepth; k++) begin
            o_commit.bytes[k] = (wr_en && wr_idx == tlvnp_pkg::CapIdxW'(k)) ?
                                i_byte : r_cap[k];
        end
        o_commit.gps_time = 1'b0;
        o_commit.antenna  = 1'b0;
        o_commit.filter   = 1'b0;
        o_commit.aiding   = 1'b0;
        unique case (code_now)
            tlvnp_pkg::DescGpsTime: begin
                o_commit.gps_time = field_done && (size_now >= tlvnp_pkg::MinGpsTime);
            end
            tlvnp_pkg::DescAntenna: begin
                o_commit.antenna = field_done && (size_now >= tlvnp_pkg::MinAntenna);
            end
            tlvnp_pkg::DescFilter: begin
                o_commit.filter = field_done && (size_now >= tlvnp_pkg::MinFilter);
            end
            tlvnp_pkg::DescAiding: begin
                o_commit.aiding = field_done && (size_now >= tlvnp_pkg::MinAiding);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 8'd0;
            r_size   <= 8'd0;
            r_code   <= 8'd0;
            r_halted <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_size   <= n_size;
            r_code   <= n_code;
            r_halted <= n_halted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cap[wr_idx] <= i_byte;
        end
    end

endmodule

[hdl/tlv_navigation_field_parser.sv]
// Channel   Direction  Beat contents
// s_axis    in         tdata[7:0] payload_byte, tlast payload_last
// m_axis    out        tdata[271:0] full navigation record, one beat per payload
//
// A new payload byte is accepted in every cycle in which the result register
// is empty or is being drained in the same cycle.
// The result beat appears in the cycle after the last payload byte is accepted.
// Reset (synchronous, active low) clears the field walker and the kept record.
// A stalled result holds s_axis_tready low until the beat is taken.
module tlv_navigation_field_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] payload_byte
    input  logic [7:0]   s_axis_tdata,
    // payload_last
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] gps_time_bits, [95:64] antenna_heading_bits,
    // [127:96] heading_uncertainty_bits, [135:128] fix_kind,
    // [151:136] antenna_status, [167:152] antenna_valid,
    // [183:168] filter_mode, [199:184] dynamics_mode, [215:200] filter_status,
    // [247:216] aiding_time_bits, [271:248] aiding_details
    output logic [271:0] m_axis_tdata
);

    logic               take;
    tlvnp_pkg::t_commit commit;

    // Kept record, updated as each wanted field completes.
    logic [63:0] r_gps, n_gps;
    logic [31:0] r_heading, n_heading;
    logic [31:0] r_uncert, n_uncert;
    logic [7:0]  r_fix, n_fix;
    logic [31:0] r_ant_words, n_ant_words;
    logic [47:0] r_filt_words, n_filt_words;
    logic [55:0] r_aiding, n_aiding;

    logic                          r_out_valid;
    logic [tlvnp_pkg::RecordW-1:0] r_out_data;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;

    tlvnp_field_walker u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_commit (commit)
    );

    // Field data is big endian; capture byte 0 is the first data byte.
    always_comb begin
        n_gps        = r_gps;
        n_heading    = r_heading;
        n_uncert     = r_uncert;
        n_fix        = r_fix;
        n_ant_words  = r_ant_words;
        n_filt_words = r_filt_words;
        n_aiding     = r_aiding;
        if (commit.gps_time) begin
            n_gps = {commit.bytes[0], commit.bytes[1], commit.bytes[2], commit.bytes[3],
                     commit.bytes[4], commit.bytes[5], commit.bytes[6], commit.bytes[7]};
        end
        if (commit.antenna) begin
            n_heading   = {commit.bytes[4], commit.bytes[5],
                           commit.bytes[6], commit.bytes[7]};
            n_uncert    = {commit.bytes[8], commit.bytes[9],
                           commit.bytes[10], commit.bytes[11]};
            n_fix       = commit.bytes[12];
            n_ant_words = {commit.bytes[13], commit.bytes[14],
                           commit.bytes[15], commit.bytes[16]};
        end
        if (commit.filter) begin
            n_filt_words = {commit.bytes[0], commit.bytes[1], commit.bytes[2],
                            commit.bytes[3], commit.bytes[4], commit.bytes[5]};
        end
        if (commit.aiding) begin
            n_aiding = {commit.bytes[0], commit.bytes[1], commit.bytes[2], commit.bytes[3],
                        commit.bytes[4], commit.bytes[5], commit.bytes[6]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gps        <= '0;
            r_heading    <= '0;
            r_uncert     <= '0;
            r_fix        <= '0;
            r_ant_words  <= '0;
            r_filt_words <= '0;
            r_aiding     <= '0;
        end else begin
            r_gps        <= n_gps;
            r_heading    <= n_heading;
            r_uncert     <= n_uncert;
            r_fix        <= n_fix;
            r_ant_words  <= n_ant_words;
            r_filt_words <= n_filt_words;
            r_aiding     <= n_aiding;
        end
    end

    // Result register: loaded with the record as it stands after the last byte.
    // The aiding time sits below the aiding details in the beat.
    always_ff @(posedge i_clk) begin
        if (take && s_axis_tlast) begin
            r_out_data <= {n_aiding[23:0], n_aiding[55:24],
                           n_filt_words[15:0], n_filt_words[31:16], n_filt_words[47:32],
                           n_ant_words[15:0], n_ant_words[31:16],
                           n_fix, n_uncert, n_heading, n_gps};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    // A result beat only ever follows an accepted last payload byte.
    a_rise_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(take && s_axis_tlast))
        else $error("result beat without a last payload byte");

    // An accepted last byte always leaves a result beat pending.
    a_last_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && s_axis_tlast |=> m_axis_tvalid)
        else $error("last payload byte produced no result beat");

    // The input side is held off only by a result beat that is not taken.
    a_ready_only_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked result");
`endif

endmodule
